>>> rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding-window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    // window length register
    localparam int            WLEN_W     = 7;
    localparam logic [6:0]    WLEN_RESET = 7'd3;

    // per-cell deque membership
    typedef struct packed {
        logic min_ok;
        logic max_ok;
    } swmm_flags_t;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;    // a request was accepted: all cells move one place
        logic restart;  // start of a new sequence: drop every older entry
    } swmm_cell_ctrl_t;

    // number of registered levels in a binary tree over n leaves
    function automatic int tree_levels(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One place of the sample chain. Cell INDEX holds the sample of age INDEX and
// two flags telling whether that sample is still in the min and max deques.
// ----------------------------------------------------------------------------
module swmm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int INDEX        = 0,
    parameter int LEN_W        = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swmm_pkg::swmm_cell_ctrl_t      ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [LEN_W-1:0]        len_eff,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
    input  swmm_pkg::swmm_flags_t          prev_flags,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output swmm_pkg::swmm_flags_t          flags
);
    import swmm_pkg::*;

    localparam logic [LEN_W-1:0] AGE = LEN_W'(INDEX);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    swmm_flags_t                    flags_reg;
    swmm_flags_t                    flags_next;
    logic                           expired;

    assign expired = (AGE >= len_eff);

    always_comb
    begin
        if (INDEX == 0)
        begin
            // newest sample always joins both deque tails
            flags_next.min_ok = 1'b1;
            flags_next.max_ok = 1'b1;
        end
        else
        begin
            // equal values are popped from both deques
            flags_next.min_ok = !ctrl.restart && prev_flags.min_ok && !expired
                                && (prev_value < sample);
            flags_next.max_ok = !ctrl.restart && prev_flags.max_ok && !expired
                                && (prev_value > sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= prev_value;
        end
    end

    assign value = value_reg;
    assign flags = flags_reg;

endmodule

>>> rtl/swmm_head_tree.sv
// ----------------------------------------------------------------------------
// swmm_head_tree
// Registered binary selection tree: returns the value of the oldest (highest
// index) leaf whose flag is set. Each tree level is registered and advances only while en is high.
// ----------------------------------------------------------------------------
module swmm_head_tree #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int LEAVES       = 64
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [SAMPLE_WIDTH-1:0] leaf_value [LEAVES],
    input  logic        [LEAVES-1:0]       leaf_vld,
    output logic signed [SAMPLE_WIDTH-1:0] root_value
);
    import swmm_pkg::*;

    localparam int LVL   = tree_levels(LEAVES);
    localparam int NP    = 1 << LVL;
    localparam int NODES = NP - 1;
    localparam int TAPS  = 2 * NP - 1;

    // heap order: node n has children 2n+1 (younger) and 2n+2 (older)
    logic signed [SAMPLE_WIDTH-1:0] node_val_reg [NODES];
    logic        [NODES-1:0]        node_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] tap_val [TAPS];
    logic        [TAPS-1:0]         tap_vld;

    genvar t;
    generate
        for (t = 0; t < TAPS; t++)
        begin : g_tap
            if (t < NODES)
            begin : g_node
                assign tap_val[t] = node_val_reg[t];
                assign tap_vld[t] = node_vld_reg[t];
            end
            else if (t - NODES < LEAVES)
            begin : g_leaf
                assign tap_val[t] = leaf_value[t - NODES];
                assign tap_vld[t] = leaf_vld[t - NODES];
            end
            else
            begin : g_pad
                assign tap_val[t] = '0;
                assign tap_vld[t] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                node_val_reg[n] <= tap_vld[2*n+2] ? tap_val[2*n+2] : tap_val[2*n+1];
                node_vld_reg[n] <= tap_vld[2*n+2] | tap_vld[2*n+1];
            end
        end
    end

    assign root_value = tap_val[0];

endmodule

>>> rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Sliding-window minimum and maximum of a signed sample stream.
// ----------------------------------------------------------------------------
// Samples shift through a chain of WINDOW_MAX cells, cell i holding the sample
// of age i and two flags for membership in the rising (min) and falling (max)
// deques; every cell compares its sample with the new one in parallel, so a
// request is taken every cycle while the output register is free or being
// emptied. The window head of each deque is picked by a registered selection
// tree of ceil(log2(WINDOW_MAX)) levels (one level at least), and each result
// is then registered at the output. A stalled output holds the whole
// pipeline. window_len values of 0 act as 1 and values above WINDOW_MAX act
// as WINDOW_MAX; results start once window_len samples of the current
// sequence have arrived.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_len_we,
    input  logic [swmm_pkg::WLEN_W-1:0]    window_len,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           start_of_sequence,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] window_min,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);
    import swmm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int LVL   = tree_levels(WINDOW_MAX);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);

    logic [WLEN_W-1:0]              window_len_reg;
    logic [LEN_W-1:0]               len_eff;
    logic [LEN_W-1:0]               len_raw;
    logic [LEN_W-1:0]               fc_reg;
    logic [LEN_W-1:0]               fc_base;
    logic [LEN_W-1:0]               fc_next;
    logic [LEN_W:0]                 fc_inc;
    logic                           has_result;
    logic                           en;
    logic                           accept;
    logic [LVL:0]                   tok_reg;
    logic [LVL:0]                   tok_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_head;
    logic signed [SAMPLE_WIDTH-1:0] max_head;
    swmm_cell_ctrl_t                cell_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
    swmm_flags_t                    cell_flags [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          min_vec;
    logic [WINDOW_MAX-1:0]          max_vec;

    // the whole pipeline moves unless a result waits untaken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_RESET;
        end
        else if (window_len_we)
        begin
            window_len_reg <= window_len;
        end
    end

    always_comb
    begin
        len_raw = LEN_W'(window_len_reg);
        if (len_raw == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_raw > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    // filled count saturates at the effective window length
    assign fc_base    = start_of_sequence ? '0 : fc_reg;
    assign fc_inc     = (LEN_W+1)'(fc_base) + (LEN_W+1)'(1);
    assign has_result = (fc_inc >= (LEN_W+1)'(len_eff));
    assign fc_next    = has_result ? len_eff : fc_inc[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= '0;
        end
        else if (accept)
        begin
            fc_reg <= fc_next;
        end
    end

    assign cell_ctrl.shift   = accept;
    assign cell_ctrl.restart = start_of_sequence;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                swmm_cell #(
                    .SAMPLE_WIDTH (SAMPLE_WIDTH),
                    .INDEX        (i),
                    .LEN_W        (LEN_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .sample     (sample),
                    .len_eff    (len_eff),
                    .prev_value (sample),
                    .prev_flags ('1),
                    .value      (cell_value[i]),
                    .flags      (cell_flags[i])
                );
            end
            else
            begin : g_rest
                swmm_cell #(
                    .SAMPLE_WIDTH (SAMPLE_WIDTH),
                    .INDEX        (i),
                    .LEN_W        (LEN_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .sample     (sample),
                    .len_eff    (len_eff),
                    .prev_value (cell_value[i-1]),
                    .prev_flags (cell_flags[i-1]),
                    .value      (cell_value[i]),
                    .flags      (cell_flags[i])
                );
            end
            assign min_vec[i] = cell_flags[i].min_ok;
            assign max_vec[i] = cell_flags[i].max_ok;
        end
    endgenerate

    swmm_head_tree #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LEAVES       (WINDOW_MAX)
    ) u_min_tree (
        .clk        (clk),
        .en         (en),
        .leaf_value (cell_value),
        .leaf_vld   (min_vec),
        .root_value (min_head)
    );

    swmm_head_tree #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LEAVES       (WINDOW_MAX)
    ) u_max_tree (
        .clk        (clk),
        .en         (en),
        .leaf_value (cell_value),
        .leaf_vld   (max_vec),
        .root_value (max_head)
    );

    // token per pipeline stage: set when that stage carries a result
    assign tok_next = {tok_reg[LVL-1:0], accept && has_result};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tok_reg       <= tok_next;
            out_valid_reg <= tok_reg[LVL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tok_reg[LVL])
        begin
            min_reg <= min_head;
            max_reg <= max_head;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_min = min_reg;
    assign window_max = max_reg;

    // a waiting result blocks new requests
    a_stall_blocks_input : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready
    ) else $error("request accepted while result stalled");

    // a new sequence leaves only the newest sample in each deque
    a_restart_clears : assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && start_of_sequence) |=>
            ($countones(min_vec) == 1) && ($countones(max_vec) == 1)
    ) else $error("deques not cleared on start of sequence");

    // the newest sample always sits in both deques after a request
    a_tail_present : assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> (min_vec[0] && max_vec[0])
    ) else $error("newest sample missing from a deque");

    // window minimum never exceeds window maximum
    a_min_le_max : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_min <= window_max)
    ) else $error("window minimum above window maximum");

endmodule
